FILE: rtl/core/strided_view_offset_map_assert.svh
// Assertion macros for the strided view offset map
`ifndef STRIDED_VIEW_OFFSET_MAP_ASSERT_SVH
`define STRIDED_VIEW_OFFSET_MAP_ASSERT_SVH

// consequent holds in the cycle after antecedent
`define SVOM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// condition holds at every edge out of reset
`define SVOM_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

FILE: rtl/core/svom_pkg.sv
// Package: constants and types for the strided view offset map
package svom_pkg;
   localparam int unsigned MaxDims  = 4;
   localparam int unsigned DefDims  = 4;
   localparam int unsigned DataW    = 32;
   localparam int unsigned CsrIdxW  = 4;
   localparam int unsigned QBits    = 2;   // quotient bits resolved per divider stage
   localparam int unsigned DivStages = DataW / QBits;

   localparam logic [CsrIdxW-1:0] CsrOutStride0 = 4'd0;
   localparam logic [CsrIdxW-1:0] CsrInStride0  = 4'd4;
   localparam logic [CsrIdxW-1:0] CsrLimit      = 4'd8;

   // per-item state carried through the divider stages
   typedef struct packed {
      logic             vld;
      logic [DataW-1:0] rem;   // partial remainder
      logic [DataW-1:0] num;   // dividend bits not yet consumed (msb first)
      logic [DataW-1:0] quo;   // quotient bits so far
      logic [DataW-1:0] acc;   // offset so far
   } div_stage_type;
endpackage

FILE: rtl/core/svom_div_step.sv
// One divider stage: retires QBits quotient bits by restoring division
module svom_div_step import svom_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [DataW-1:0] divisor,
   input  div_stage_type    stage_in,
   output div_stage_type    stage_out
);
   div_stage_type stage_ff, stage_in_c;
   logic [DataW:0] r;
   logic [DataW:0] diff;

   always_comb begin
      stage_in_c = stage_in;
      for (int b = 0; b < QBits; b++) begin
         r = {stage_in_c.rem, stage_in_c.num[DataW-1]};
         diff = r - {1'b0, divisor};
         stage_in_c.num = {stage_in_c.num[DataW-2:0], 1'b0};
         if (!diff[DataW]) begin
            stage_in_c.rem = diff[DataW-1:0];
            stage_in_c.quo = {stage_in_c.quo[DataW-2:0], 1'b1};
         end else begin
            stage_in_c.rem = r[DataW-1:0];
            stage_in_c.quo = {stage_in_c.quo[DataW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.vld <= 1'b0;
      end else begin
         stage_ff.vld <= stage_in.vld;
      end
      stage_ff.rem <= stage_in_c.rem;
      stage_ff.num <= stage_in_c.num;
      stage_ff.quo <= stage_in_c.quo;
      stage_ff.acc <= stage_in_c.acc;
   end

   assign stage_out = stage_ff;
endmodule

FILE: rtl/core/svom_dim.sv
// One dimension: pipelined divide, then multiply and accumulate
module svom_dim import svom_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [DataW-1:0] out_stride,
   input  logic [DataW-1:0] in_stride,
   input  logic             vld_in,
   input  logic [DataW-1:0] pos_in,
   input  logic [DataW-1:0] acc_in,
   output logic             vld_out,
   output logic [DataW-1:0] pos_out,
   output logic [DataW-1:0] acc_out
);
   div_stage_type chain [DivStages+1];
   logic             mul_vld_ff, sum_vld_ff;
   logic [DataW-1:0] mul_ff, mul_in, rest_ff, acc_ff, sum_ff, sum_in, rest2_ff;

   assign chain[0] = '{vld: vld_in, rem: '0, num: pos_in, quo: '0, acc: acc_in};

   for (genvar g = 0; g < DivStages; g++) begin : g_div
      svom_div_step u_step (
         .clock(clock), .reset(reset), .divisor(out_stride),
         .stage_in(chain[g]), .stage_out(chain[g+1])
      );
   end

   // zero stride: coordinate 0, position passes through (dividing by 0 gives all-ones quotient)
   always_comb begin
      mul_in = (out_stride == '0) ? '0 : chain[DivStages].quo * in_stride;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
         sum_vld_ff <= 1'b0;
      end else begin
         mul_vld_ff <= chain[DivStages].vld;
         sum_vld_ff <= mul_vld_ff;
      end
      mul_ff   <= mul_in;
      // with divisor 0 each step subtracts nothing, so rem ends as the dividend
      rest_ff  <= chain[DivStages].rem;
      acc_ff   <= chain[DivStages].acc;
      sum_ff   <= sum_in;
      rest2_ff <= rest_ff;
   end

   assign sum_in  = acc_ff + mul_ff;
   assign vld_out = sum_vld_ff;
   assign pos_out = rest2_ff;
   assign acc_out = sum_ff;
endmodule

FILE: rtl/core/strided_view_offset_map.sv
// Top level: strided view position to source offset map
// channel | ports                           | dir
// req     | start, busy, req_linear_position | in, busy out
// rsp     | rsp_valid, rsp_source_offset      | out
// csr     | csr_we, csr_index, csr_wdata      | in
// One request per cycle; each request passes through the divider stages of
// each dimension followed by multiply and add registers.
// Reset clears valid bits and strides (out 1, in 0). busy is always low:
// the pipeline never stalls and the receiver cannot hold results off.
module strided_view_offset_map import svom_pkg::*; #(
   parameter int unsigned DIMS = DefDims
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [DataW-1:0]     req_linear_position,
   output logic                 rsp_valid,
   output logic signed [DataW-1:0] rsp_source_offset,
   input  logic                 csr_we,
   input  logic [CsrIdxW-1:0]   csr_index,
   input  logic [DataW-1:0]     csr_wdata
);
   logic [DataW-1:0] out_stride_ff [MaxDims];
   logic [DataW-1:0] in_stride_ff  [MaxDims];
   logic             vld   [DIMS+1];
   logic [DataW-1:0] pos   [DIMS+1];
   logic [DataW-1:0] acc   [DIMS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < MaxDims; d++) begin
            out_stride_ff[d] <= DataW'(1);
            in_stride_ff[d]  <= '0;
         end
      end else if (csr_we && csr_index < CsrLimit) begin
         if (csr_index < CsrInStride0) begin
            out_stride_ff[csr_index[1:0]] <= csr_wdata;
         end else begin
            in_stride_ff[csr_index[1:0]] <= csr_wdata;
         end
      end
   end

   assign busy   = 1'b0;
   assign vld[0] = start;
   assign pos[0] = req_linear_position;
   assign acc[0] = '0;

   for (genvar g = 0; g < DIMS; g++) begin : g_dim
      svom_dim u_dim (
         .clock(clock), .reset(reset),
         .out_stride(out_stride_ff[g]), .in_stride(in_stride_ff[g]),
         .vld_in(vld[g]), .pos_in(pos[g]), .acc_in(acc[g]),
         .vld_out(vld[g+1]), .pos_out(pos[g+1]), .acc_out(acc[g+1])
      );
   end

   assign rsp_valid         = vld[DIMS];
   assign rsp_source_offset = acc[DIMS];

`include "strided_view_offset_map_assert.svh"
   `SVOM_ASSERT_ALWAYS(a_busy_low, clock, reset, !busy, "busy raised")
   `SVOM_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid || DIMS == 0, "valid after reset")
   `SVOM_ASSERT_NEXT(a_stride_nonzero_rst, clock, 1'b0, reset, out_stride_ff[0] == DataW'(1), "stride reset")
endmodule

FILE: tb/strided_view_offset_map_tb.sv
// Testbench for the strided view offset map: directed table, then random requests
`timescale 1ns / 1ps

module strided_view_offset_map_tb;
   import svom_pkg::*;

   localparam int unsigned Latency    = 4 * (DataW / QBits + 2);
   localparam int unsigned RandomReqs = 1950;
   localparam int unsigned StallLimit = 20 * Latency + 1000;
   localparam int unsigned NumRegs    = 8;

   typedef struct {
      logic [DataW-1:0] pos;
      logic             known;
      logic [DataW-1:0] offset;
   } row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [DataW-1:0]     req_linear_position = '0;
   logic                 rsp_valid;
   logic signed [DataW-1:0] rsp_source_offset;
   logic                 csr_we = 1'b0;
   logic [CsrIdxW-1:0]   csr_index = '0;
   logic [DataW-1:0]     csr_wdata = '0;

   logic [DataW-1:0] out_stride_q [MaxDims];
   logic [DataW-1:0] in_stride_q  [MaxDims];
   logic [DataW-1:0] pending_offsets [$];
   bit               failed = 1'b0;
   int unsigned      idle_cycles = 0;
   row_type          dir_rows [$];

   strided_view_offset_map dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_linear_position(req_linear_position),
      .rsp_valid(rsp_valid), .rsp_source_offset(rsp_source_offset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [DataW-1:0] source_offset_of(logic [DataW-1:0] pos);
      logic [DataW-1:0] rest;
      logic [DataW-1:0] acc;
      rest = pos;
      acc  = '0;
      for (int d = 0; d < DefDims; d++) begin
         // zero stride: coordinate 0, position passes on unchanged
         if (out_stride_q[d] != '0) begin
            acc  = acc + (rest / out_stride_q[d]) * in_stride_q[d];
            rest = rest % out_stride_q[d];
         end
      end
      return acc;
   endfunction

   // result checker; results cannot be held off
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) idle_cycles <= 0;
         else if (rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid) begin
            if (pending_offsets.size() == 0) begin
               $display("%0t: unexpected result, actual %h", $time, rsp_source_offset);
               failed = 1'b1;
            end else begin
               logic [DataW-1:0] exp_off;
               exp_off = pending_offsets.pop_front();
               if (rsp_source_offset !== exp_off) begin
                  $display("%0t: source_offset mismatch, expected %h actual %h",
                           $time, exp_off, rsp_source_offset);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= StallLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [DataW-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx < CsrInStride0) out_stride_q[idx[1:0]] = val;
      else if (idx < CsrLimit) in_stride_q[idx[1:0]] = val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain;
      while (pending_offsets.size() != 0) @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
   endtask

   // one request; gap chance in percent; a known offset replaces the predictor
   task automatic send_request(input logic [DataW-1:0] pos, input int unsigned gap_pct,
                               input bit known = 1'b0,
                               input logic [DataW-1:0] exp_val = '0);
      @(posedge clock);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start               <= 1'b1;
      req_linear_position <= pos;
      #0.1;
      while (busy) @(posedge clock);
      if (known) pending_offsets.push_back(exp_val);
      else pending_offsets.push_back(source_offset_of(pos));
      @(negedge clock);
   endtask

   task automatic stop_requests;
      @(posedge clock);
      start <= 1'b0;
   endtask

   task automatic run_rows;
      foreach (dir_rows[i])
         send_request(dir_rows[i].pos, 0, dir_rows[i].known, dir_rows[i].offset);
      stop_requests();
      drain();
      dir_rows.delete();
   endtask

   function automatic logic [DataW-1:0] rand_pos();
      case ($urandom_range(3))
         0: return $urandom_range(255);
         1: return $urandom_range(65535);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DataW-1:0] rand_out_stride();
      case ($urandom_range(5))
         0: return 32'd1;
         1: return 32'hFFFF_FFFF;
         2: return '0;
         3: return $urandom_range(16, 1);
         4: return $urandom_range(4096, 1);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DataW-1:0] rand_in_stride();
      case ($urandom_range(4))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(8) - 4;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      for (int d = 0; d < MaxDims; d++) begin
         out_stride_q[d] = 32'd1;
         in_stride_q[d]  = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // after reset every offset is zero
      dir_rows.push_back('{32'd0, 1'b1, 32'd0});
      dir_rows.push_back('{32'hFFFF_FFFF, 1'b1, 32'd0});
      dir_rows.push_back('{32'h8000_0000, 1'b1, 32'd0});
      run_rows();

      // row-major 2x3x4x5 view, then extremes and a zero stride
      write_reg(CsrIdxW'(CsrOutStride0 + 0), 32'd60);
      write_reg(CsrIdxW'(CsrOutStride0 + 1), 32'd20);
      write_reg(CsrIdxW'(CsrOutStride0 + 2), 32'd5);
      write_reg(CsrIdxW'(CsrOutStride0 + 3), 32'd1);
      write_reg(CsrIdxW'(CsrInStride0 + 0), 32'd1);
      write_reg(CsrIdxW'(CsrInStride0 + 1), 32'd2);
      write_reg(CsrIdxW'(CsrInStride0 + 2), 32'hFFFF_FFFD);
      write_reg(CsrIdxW'(CsrInStride0 + 3), 32'h7FFF_FFFF);
      write_reg(CsrLimit, 32'hDEAD_BEEF);      // out of range index, ignored
      write_reg(CsrIdxW'(CsrLimit + 7), 32'h1234_5678);
      dir_rows.push_back('{32'd0, 1'b1, 32'd0});
      dir_rows.push_back('{32'd119, 1'b0, 32'd0});
      dir_rows.push_back('{32'd59, 1'b0, 32'd0});
      dir_rows.push_back('{32'd60, 1'b0, 32'd0});
      dir_rows.push_back('{32'hFFFF_FFFF, 1'b0, 32'd0});
      dir_rows.push_back('{32'h8000_0000, 1'b0, 32'd0});
      for (int i = 0; i < 6; i++) dir_rows.push_back('{rand_pos(), 1'b0, 32'd0});
      run_rows();

      write_reg(CsrIdxW'(CsrOutStride0 + 1), '0);   // zero stride passes position on
      write_reg(CsrIdxW'(CsrOutStride0 + 3), 32'hFFFF_FFFF);
      write_reg(CsrIdxW'(CsrInStride0 + 0), 32'h8000_0000);
      dir_rows.push_back('{32'd0, 1'b1, 32'd0});
      dir_rows.push_back('{32'hFFFF_FFFF, 1'b0, 32'd0});
      for (int i = 0; i < 6; i++) dir_rows.push_back('{rand_pos(), 1'b0, 32'd0});
      run_rows();

      // random phases with fresh stride settings
      for (int ph = 0; ph < 10; ph++) begin
         for (int r = 0; r < NumRegs; r++)
            write_reg(CsrIdxW'(r), r < CsrInStride0 ? rand_out_stride() : rand_in_stride());
         for (int i = 0; i < RandomReqs / 10; i++)
            send_request(rand_pos(), (ph == 3) ? 0 : 24);
         stop_requests();
         drain();
      end

      if (!failed) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/svom_pkg.sv
rtl/core/svom_div_step.sv
rtl/core/svom_dim.sv
rtl/core/strided_view_offset_map.sv
tb/strided_view_offset_map_tb.sv
